// ===== hdl/sdtq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtq_pkg - shared types and codes of the sorted deadline timer queue
// Operation, status and cell command codes plus the entry and link types
// passed between the queue cells and the controller.
// ----------------------------------------------------------------------------
package sdtq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int RESULT_LIMIT = 16;
   localparam int DEADLINE_W   = 32;
   localparam int HANDLE_W     = 16;
   localparam int OCC_W        = 5;
   localparam int STATUS_W     = 3;
   localparam int OP_W         = 2;
   localparam int RLIM_W       = $clog2(RESULT_LIMIT + 1);

   // operation codes (req_tuser)
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_ADJUST = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

   // status codes (rsp_tuser)
   localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXPIRED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NONE     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DUP      = 3'd5;

   // commands broadcast to every cell
   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_NONE = 2'd0;
   localparam cmd_type CMD_INS  = 2'd1;
   localparam cmd_type CMD_DEL  = 2'd2;
   localparam cmd_type CMD_POP  = 2'd3;

   typedef struct packed {
      logic [DEADLINE_W-1:0] deadline;
      logic [HANDLE_W-1:0]   handle;
   } entry_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic      valid;
      logic      greater;
      entry_type entry;
   } cell_link_type;

endpackage

// ===== hdl/sdtq_cell.sv =====
// ----------------------------------------------------------------------------
// sdtq_cell - one slot of the sorted timer chain
// Holds one entry; on insert shifts toward the tail past the new key, on
// delete or pop takes its right neighbor when the removal point is at or
// before it.
// ----------------------------------------------------------------------------
module sdtq_cell
   import sdtq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  entry_type     new_entry,
   input  cell_link_type prev_link,
   input  cell_link_type next_link,
   input  logic          chain_in,
   output logic          chain_out,
   output logic          match,
   output cell_link_type link_out
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      greater;
   logic      rm_here;

   assign greater  = valid_ff && (entry_ff.deadline > new_entry.deadline);
   assign match    = valid_ff && (entry_ff.handle == new_entry.handle);
   // removal point is here or somewhere to the left
   assign rm_here   = chain_in || ((cmd == CMD_DEL) && match);
   assign chain_out = rm_here;

   assign link_out.valid   = valid_ff;
   assign link_out.greater = greater;
   assign link_out.entry   = entry_ff;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      case (cmd)
         CMD_INS: begin
            if (prev_link.greater) begin
               valid_in = 1'b1;
               entry_in = prev_link.entry;
            end else if (greater || (!valid_ff && prev_link.valid)) begin
               valid_in = 1'b1;
               entry_in = new_entry;
            end
         end
         CMD_DEL, CMD_POP: begin
            if (rm_here) begin
               valid_in = next_link.valid;
               entry_in = next_link.entry;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hdl/sorted_deadline_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue - timer list kept sorted by deadline
// A chain of cells holds the timers in ascending deadline order; a small
// controller runs insert, adjust, delete and tick on it.
// ----------------------------------------------------------------------------
// usage
//   req channel: one word per operation; req_tuser is the operation,
//   req_tdata carries handle and deadline (or current time for a tick)
//   rsp channel: one word per result; rsp_tlast marks the final word of an
//   operation, rsp_tuser the status
//   insert, delete and a failed adjust run a single pass after the accept;
//   a successful adjust runs a remove pass, then an insert pass
//   a tick pops each expired timer from the head of the chain, one per
//   cycle while the output is free to take it, up to 16 per tick;
//   a tick with nothing expired returns a single none word
//   every pass is one broadcast to all cells, so the cost does not grow
//   with capacity
//   a new word is taken only once the previous operation has finished, but
//   a finished result may still wait in the output register meanwhile
//   when rsp_tready is low the controller holds in place with nothing lost
//   reset empties the queue at once (valid bits clear), no clearing pass
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue
   import sdtq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // handle [15:0], time_value [47:16]
   input  logic [1:0]  req_tuser,   // operation [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_handle [15:0], occupancy [20:16], zero [23:21]
   output logic [2:0]  rsp_tuser,   // status [2:0]
   output logic        rsp_tlast
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // controller states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_ADJ  = 2'd2;
   localparam logic [1:0] S_TICK = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [HANDLE_W-1:0]   handle_ff, handle_in;
   logic [DEADLINE_W-1:0] time_ff, time_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [RLIM_W-1:0]     k_ff, k_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [OCC_W-1:0]      rsp_occ_ff, rsp_occ_in;
   logic                  rsp_last_ff, rsp_last_in;

   // cell chain
   cmd_type               cmd;
   entry_type             new_entry;
   cell_link_type         link_vec [CAPACITY];
   cell_link_type         prev_vec [CAPACITY];
   cell_link_type         next_vec [CAPACITY];
   logic [CAPACITY:0]     chain_vec;
   logic [CAPACITY-1:0]   match_vec;
   logic [CAPACITY-1:0]   valid_vec;

   logic                  out_free;
   logic                  match_any;
   logic                  head_expired;
   logic                  next_expired;
   logic                  tick_last;

   // emitted result, before saturation of the occupancy
   logic                  emit;
   logic [STATUS_W-1:0]   e_status;
   logic [HANDLE_W-1:0]   e_handle;
   logic [CNT_W-1:0]      e_cnt;
   logic                  e_last;

   assign new_entry.deadline = time_ff;
   assign new_entry.handle   = handle_ff;
   // removal starts at the head for a pop
   assign chain_vec[0]       = (cmd == CMD_POP);

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            assign prev_vec[gi] = '{valid: 1'b1, greater: 1'b0, entry: '0};
         end else begin : g_mid
            assign prev_vec[gi] = link_vec[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign next_vec[gi] = '{valid: 1'b0, greater: 1'b0, entry: '0};
         end else begin : g_body
            assign next_vec[gi] = link_vec[gi+1];
         end

         sdtq_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .new_entry (new_entry),
            .prev_link (prev_vec[gi]),
            .next_link (next_vec[gi]),
            .chain_in  (chain_vec[gi]),
            .chain_out (chain_vec[gi+1]),
            .match     (match_vec[gi]),
            .link_out  (link_vec[gi])
         );

         assign valid_vec[gi] = link_vec[gi].valid;
      end
   endgenerate

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign match_any    = |match_vec;
   assign head_expired = link_vec[0].valid && (link_vec[0].entry.deadline <= time_ff);
   assign next_expired = link_vec[1].valid && (link_vec[1].entry.deadline <= time_ff);
   // final pop of this tick: the next head stays or the word limit is hit
   assign tick_last    = !next_expired || (k_ff == RLIM_W'(RESULT_LIMIT - 1));

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      handle_in = handle_ff;
      time_in   = time_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      cmd       = CMD_NONE;
      emit      = 1'b0;
      e_status  = ST_DONE;
      e_handle  = handle_ff;
      e_cnt     = cnt_ff;
      e_last    = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               handle_in = req_tdata[15:0];
               time_in   = req_tdata[47:16];
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
               case (op_ff)
                  OP_INSERT: begin
                     emit = 1'b1;
                     if (match_any) begin
                        e_status = ST_DUP;
                     end else if (cnt_ff == CNT_W'(CAPACITY)) begin
                        e_status = ST_FULL;
                     end else begin
                        cmd    = CMD_INS;
                        cnt_in = cnt_ff + CNT_W'(1);
                        e_cnt  = cnt_ff + CNT_W'(1);
                     end
                  end
                  OP_ADJUST: begin
                     if (!match_any) begin
                        emit     = 1'b1;
                        e_status = ST_NOTFOUND;
                     end else begin
                        // take it out now, put it back next cycle
                        cmd      = CMD_DEL;
                        cnt_in   = cnt_ff - CNT_W'(1);
                        state_in = S_ADJ;
                     end
                  end
                  OP_DELETE: begin
                     emit = 1'b1;
                     if (!match_any) begin
                        e_status = ST_NOTFOUND;
                     end else begin
                        cmd    = CMD_DEL;
                        cnt_in = cnt_ff - CNT_W'(1);
                        e_cnt  = cnt_ff - CNT_W'(1);
                     end
                  end
                  OP_TICK: begin
                     k_in     = '0;
                     state_in = S_TICK;
                  end
                  default: ;
               endcase
            end
         end
         S_ADJ: begin
            if (out_free) begin
               cmd      = CMD_INS;
               cnt_in   = cnt_ff + CNT_W'(1);
               emit     = 1'b1;
               e_cnt    = cnt_ff + CNT_W'(1);
               state_in = S_IDLE;
            end
         end
         S_TICK: begin
            if (out_free) begin
               emit = 1'b1;
               if (head_expired) begin
                  cmd      = CMD_POP;
                  cnt_in   = cnt_ff - CNT_W'(1);
                  k_in     = k_ff + RLIM_W'(1);
                  e_status = ST_EXPIRED;
                  e_handle = link_vec[0].entry.handle;
                  e_cnt    = cnt_ff - CNT_W'(1);
                  e_last   = tick_last;
                  if (tick_last) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  // only reached before any pop of this tick
                  e_status = ST_NONE;
                  e_handle = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register, occupancy saturates at the field width
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = e_status;
         rsp_handle_in = e_handle;
         rsp_last_in   = e_last;
         if (32'(e_cnt) > 32'd31) begin
            rsp_occ_in = 5'd31;
         end else begin
            rsp_occ_in = OCC_W'(e_cnt);
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      handle_ff     <= handle_in;
      time_ff       <= time_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_occ_ff, rsp_handle_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // held entries fill the chain from the head; their number matches the count
   a_valid_prefix : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(cnt_ff))
      else $error("valid cells do not match occupancy count");

   // handles are unique, so at most one cell can match
   a_unique_handle : assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("handle held in more than one cell");

   // count never runs past the chain length
   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= CAPACITY)
      else $error("occupancy count beyond capacity");

   // an adjust that removed its entry puts it back on the next pass
   a_adj_refill : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADJ) && out_free |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("adjust did not reinsert its entry");
`endif

endmodule

// ===== verif/sdtq_checker.sv =====
// ----------------------------------------------------------------------------
// sdtq_checker - result checker for the sorted deadline timer queue
// Watches both streams, keeps a sorted timer list of its own, predicts
// every rsp word from each accepted req word and compares them in order.
// ----------------------------------------------------------------------------
module sdtq_checker
   import sdtq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // handle [15:0], time_value [47:16]
   input  logic [1:0]  req_tuser,   // operation [1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // out_handle [15:0], occupancy [20:16], zero [23:21]
   input  logic [2:0]  rsp_tuser,   // status [2:0]
   input  logic        rsp_tlast,
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle;
      logic [OCC_W-1:0]    occupancy;
      logic                last;
   } result_word_type;

   entry_type       timer_list[$];      // ascending deadline, head first
   result_word_type expected_words[$];

   initial begin
      failures = 0;
      pending  = 0;
   end

   function automatic int find_owner(logic [HANDLE_W-1:0] h);
      foreach (timer_list[i])
         if (timer_list[i].handle == h) return i;
      return -1;
   endfunction

   function automatic void push_word(logic [STATUS_W-1:0] status,
                                     logic [HANDLE_W-1:0] h, logic last);
      result_word_type w;
      int              n;
      n           = timer_list.size();
      w.status    = status;
      w.handle    = h;
      w.occupancy = (n > 31) ? OCC_W'(31) : OCC_W'(n);
      w.last      = last;
      expected_words.push_back(w);
   endfunction

   // goes after every entry with an equal deadline
   function automatic void place_timer(logic [HANDLE_W-1:0] h,
                                       logic [DEADLINE_W-1:0] d);
      entry_type e;
      int        pos;
      pos = 0;
      while (pos < timer_list.size() && timer_list[pos].deadline <= d)
         pos++;
      e.deadline = d;
      e.handle   = h;
      timer_list.insert(pos, e);
   endfunction

   function automatic void apply_timer_op(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
                                          logic [DEADLINE_W-1:0] t);
      int                  pos;
      int                  popped;
      bit                  more;
      logic [HANDLE_W-1:0] who;
      pos    = find_owner(h);
      popped = 0;
      case (op)
         OP_INSERT: begin
            if (pos >= 0)
               push_word(ST_DUP, h, 1'b1);
            else if (timer_list.size() >= CAPACITY)
               push_word(ST_FULL, h, 1'b1);
            else begin
               place_timer(h, t);
               push_word(ST_DONE, h, 1'b1);
            end
         end
         OP_ADJUST, OP_DELETE: begin
            if (pos < 0)
               push_word(ST_NOTFOUND, h, 1'b1);
            else begin
               timer_list.delete(pos);
               if (op == OP_ADJUST) place_timer(h, t);
               push_word(ST_DONE, h, 1'b1);
            end
         end
         default: begin
            more = timer_list.size() > 0 && timer_list[0].deadline <= t;
            if (!more) push_word(ST_NONE, '0, 1'b1);
            while (more) begin
               who = timer_list[0].handle;
               void'(timer_list.pop_front());
               popped++;
               more = timer_list.size() > 0 && popped < RESULT_LIMIT &&
                      timer_list[0].deadline <= t;
               push_word(ST_EXPIRED, who, !more);
            end
         end
      endcase
   endfunction

   task automatic check_field(string name, int expected, int actual);
      if (expected != actual) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      result_word_type w;
      if (reset) begin
         timer_list.delete();
         expected_words.delete();
      end else begin
         if (req_tvalid && req_tready)
            apply_timer_op(req_tuser, req_tdata[15:0], req_tdata[47:16]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: no word expected, got status %0d handle %0d", $time,
                        rsp_tuser, rsp_tdata[15:0]);
               failures++;
            end else begin
               w = expected_words.pop_front();
               check_field("status", w.status, rsp_tuser);
               check_field("out_handle", w.handle, rsp_tdata[15:0]);
               check_field("occupancy", w.occupancy, rsp_tdata[20:16]);
               check_field("last", w.last, rsp_tlast);
            end
         end
      end
      pending <= expected_words.size();
   end

endmodule

// ===== verif/sorted_deadline_timer_queue_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_tb - top of the timer queue testbench
// Drives directed and random insert, adjust, delete and tick words with
// random gaps and back-pressure, one long rsp stall that fills the block,
// and takes the verdict from the checker beside the block.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue_tb
   import sdtq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 450;
   localparam int QUIET_AFTER  = 420;   // no gaps or stalls past this many words
   localparam int HOLD_AFTER   = 80;    // long rsp stall starts here
   localparam int LONG_HOLD    = 300;   // cycles of that stall
   localparam int POOL_SIZE    = 24;    // more handles than the queue holds

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;       // handle [15:0], time_value [47:16]
   logic [1:0]  req_tuser = OP_INSERT; // operation [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // out_handle [15:0], occupancy [20:16], zero [23:21]
   logic [2:0]  rsp_tuser;            // status [2:0]
   logic        rsp_tlast;

   int failures;
   int pending;
   int sent_count = 0;

   always #5 clock = ~clock;

   sorted_deadline_timer_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   sdtq_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .failures   (failures),
      .pending    (pending)
   );

   // offer one word and hold it until taken; valid stays high into the
   // next word unless a gap is drawn
   task automatic issue_op(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
                           logic [DEADLINE_W-1:0] t);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {t, h};
      do @(posedge clock); while (!req_tready);
      sent_count++;
      if (sent_count < QUIET_AFTER && $urandom_range(0, 3) == 0) begin
         // idle burst, with junk on the bus while valid is low
         req_tvalid <= 1'b0;
         req_tuser  <= 2'($urandom);
         req_tdata  <= {$urandom, 16'($urandom)};
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // receiver: short random stalls, one long stall once traffic is going
   initial begin
      bit long_hold_done;
      long_hold_done = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!long_hold_done && sent_count >= HOLD_AFTER) begin
            // sender keeps offering, so the block backs up and drops req_tready
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (sent_count < QUIET_AFTER && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // stimulus
   initial begin
      logic [HANDLE_W-1:0]   handle_pool[POOL_SIZE];
      logic [HANDLE_W-1:0]   h;
      logic [DEADLINE_W-1:0] d;
      logic [DEADLINE_W-1:0] t;
      logic [DEADLINE_W-1:0] now;
      int                    pick;
      int                    r;

      foreach (handle_pool[i]) handle_pool[i] = 16'($urandom);
      now = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tick, boundary expiry, dup, extreme values
      issue_op(OP_TICK, 16'h0000, 32'd0);          // nothing held
      issue_op(OP_INSERT, 16'h0000, 32'd5);
      issue_op(OP_TICK, 16'h0000, 32'd4);          // one time unit early
      issue_op(OP_TICK, 16'h0000, 32'd5);          // deadline equal to now expires
      issue_op(OP_INSERT, 16'h0000, 32'd100);
      issue_op(OP_INSERT, 16'h0000, 32'd7);        // handle already held
      issue_op(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
      issue_op(OP_ADJUST, 16'h0000, 32'hFFFF_FFFF); // equal key, goes behind
      issue_op(OP_ADJUST, 16'h0000, 32'd3);        // move earlier
      issue_op(OP_ADJUST, 16'h1234, 32'd9);        // absent handle
      issue_op(OP_DELETE, 16'h4321, 32'd0);        // absent handle

      // fill up, with runs of equal deadlines to check arrival order
      for (int i = 0; i < 14; i++)
         issue_op(OP_INSERT, 16'(16'h0100 + i), 32'(10 + (i % 3) * 7));
      issue_op(OP_INSERT, 16'h5A5A, 32'd1);        // queue full
      issue_op(OP_INSERT, 16'hFFFF, 32'd1);        // dup wins over full
      issue_op(OP_DELETE, 16'hFFFF, 32'd0);
      issue_op(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF);  // drain everything

      // random: pooled handles so dup, adjust and delete hit held timers,
      // deadlines near a running clock so ticks expire a few at a time
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         pick = $urandom_range(0, 99);
         h    = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
         if ($urandom_range(0, 19) == 0) h = 16'($urandom);
         d = now + $urandom_range(0, 40);
         if ($urandom_range(0, 19) == 0) d = $urandom;
         if (pick < 35)
            issue_op(OP_INSERT, h, d);
         else if (pick < 55)
            issue_op(OP_ADJUST, h, d);
         else if (pick < 70)
            issue_op(OP_DELETE, h, d);
         else begin
            now = now + $urandom_range(0, 15);
            t   = now;
            r   = $urandom_range(0, 49);
            if (r == 0) t = '1;             // flush
            else if (r == 1) t = $urandom;
            issue_op(OP_TICK, h, t);        // handle is don't-care on a tick
         end
      end
      req_tvalid <= 1'b0;

      // drain, then a few more cycles to catch stray words
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (24) @(posedge clock);

      if (failures == 0)
         $display("sorted_deadline_timer_queue: match");
      else
         $display("sorted_deadline_timer_queue: mismatch");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("sorted_deadline_timer_queue: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/sdtq_pkg.sv
hdl/sdtq_cell.sv
hdl/sorted_deadline_timer_queue.sv
verif/sdtq_checker.sv
verif/sorted_deadline_timer_queue_tb.sv
